>>> rtl/sqa_pkg.sv
// ----------------------------------------------------------------------------
// sqa_pkg: shared definitions for the nearest-square root approximator
// Default widths, sequencer step and condition codes, the control word
// and the microcode ROM.
// ----------------------------------------------------------------------------
package sqa_pkg;

  localparam int unsigned IntBitsDef  = 16;
  localparam int unsigned FracBitsDef = 8;

  typedef enum logic [2:0] {
    STEP_IDLE    = 3'd0,
    STEP_SEARCH  = 3'd1,
    STEP_NSETUP  = 3'd2,
    STEP_DIV_N   = 3'd3,
    STEP_ISETUP  = 3'd4,
    STEP_DIV_I   = 3'd5,
    STEP_OUT     = 3'd6
  } step_e;

  typedef enum logic [2:0] {
    COND_ALWAYS   = 3'd0,
    COND_IN       = 3'd1,
    COND_FOUND    = 3'd2,
    COND_DIV_LAST = 3'd3,
    COND_OUT_FREE = 3'd4
  } cond_e;

  // One control word per step. The step jumps to target when cond holds,
  // otherwise it repeats.
  typedef struct packed {
    cond_e cond;
    step_e target;
    logic  ld_in;
    logic  search;
    logic  setup_newton;
    logic  setup_interp;
    logic  div;
    logic  out_load;
  } ctrl_t;

  function automatic ctrl_t ucode_rom(step_e step);
    ctrl_t cw;
    cw = '{cond: COND_ALWAYS, target: STEP_IDLE, default: 1'b0};
    unique case (step)
      STEP_IDLE: begin
        cw.cond   = COND_IN;
        cw.target = STEP_SEARCH;
        cw.ld_in  = 1'b1;
      end
      STEP_SEARCH: begin
        cw.cond   = COND_FOUND;
        cw.target = STEP_NSETUP;
        cw.search = 1'b1;
      end
      STEP_NSETUP: begin
        cw.cond         = COND_ALWAYS;
        cw.target       = STEP_DIV_N;
        cw.setup_newton = 1'b1;
      end
      STEP_DIV_N: begin
        cw.cond   = COND_DIV_LAST;
        cw.target = STEP_ISETUP;
        cw.div    = 1'b1;
      end
      STEP_ISETUP: begin
        cw.cond         = COND_ALWAYS;
        cw.target       = STEP_DIV_I;
        cw.setup_interp = 1'b1;
      end
      STEP_DIV_I: begin
        cw.cond   = COND_DIV_LAST;
        cw.target = STEP_OUT;
        cw.div    = 1'b1;
      end
      STEP_OUT: begin
        cw.cond     = COND_OUT_FREE;
        cw.target   = STEP_IDLE;
        cw.out_load = 1'b1;
      end
      default: begin
        cw.cond   = COND_ALWAYS;
        cw.target = STEP_IDLE;
      end
    endcase
    return cw;
  endfunction

endpackage

>>> rtl/sqa_in_if.sv
// ----------------------------------------------------------------------------
// sqa_in_if: input channel
// Valid/ready channel that carries one fixed-point number per transaction.
// ----------------------------------------------------------------------------
interface sqa_in_if #(
  parameter int unsigned INT_BITS  = sqa_pkg::IntBitsDef,
  parameter int unsigned FRAC_BITS = sqa_pkg::FracBitsDef
);
  localparam int unsigned IN_W = INT_BITS + FRAC_BITS;

  logic            valid;
  logic            ready;
  logic [IN_W-1:0] number_in;

  modport source (output valid, output number_in, input ready);
  modport sink   (input valid, input number_in, output ready);
endinterface

>>> rtl/sqa_out_if.sv
// ----------------------------------------------------------------------------
// sqa_out_if: result channel
// Valid/ready channel that carries both approximations and the upper root.
// ----------------------------------------------------------------------------
interface sqa_out_if #(
  parameter int unsigned INT_BITS  = sqa_pkg::IntBitsDef,
  parameter int unsigned FRAC_BITS = sqa_pkg::FracBitsDef
);
  localparam int unsigned RB       = (INT_BITS + 1) / 2;
  localparam int unsigned ROOT_W   = RB + 1;
  localparam int unsigned APPROX_W = RB + 1 + FRAC_BITS;

  logic                valid;
  logic                ready;
  logic [APPROX_W-1:0] approx_newton;
  logic [APPROX_W-1:0] approx_interp;
  logic [ROOT_W-1:0]   int_root_upper;

  modport source (output valid, output approx_newton, output approx_interp,
                  output int_root_upper, input ready);
  modport sink   (input valid, input approx_newton, input approx_interp,
                  input int_root_upper, output ready);
endinterface

>>> rtl/sqrt_approx_nearest_square.sv
// ----------------------------------------------------------------------------
// sqrt_approx_nearest_square: square root approximation by nearest square
// Microcoded sequencer over a counting root search and a shared restoring
// divider.
// ----------------------------------------------------------------------------
// One number is worked on at a time. The idle step takes the transaction,
// then the upper root r is found by counting up from 1, one candidate per
// cycle, then a setup step and a divide over NUM_W = 2*ceil(INT_BITS/2) +
// FRAC_BITS + 1 quotient bits give the Newton value, the same again gives
// the interpolation, and a last step loads the result register once the
// output register is free. The shared one-bit-per-cycle divider and the
// search counter carry the bulk of the work. The next number is taken once
// the result is in the output register, even while that result still waits.
module sqrt_approx_nearest_square #(
  parameter int unsigned INT_BITS  = sqa_pkg::IntBitsDef,
  parameter int unsigned FRAC_BITS = sqa_pkg::FracBitsDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  sqa_in_if.sink    in_i,
  sqa_out_if.source out_o
);
  import sqa_pkg::*;

  localparam int unsigned IN_W     = INT_BITS + FRAC_BITS;
  localparam int unsigned RB       = (INT_BITS + 1) / 2;
  localparam int unsigned ROOT_W   = RB + 1;
  localparam int unsigned APPROX_W = RB + 1 + FRAC_BITS;
  localparam int unsigned SQ_W     = 2 * RB + 1;
  localparam int unsigned NUM_W    = 2 * RB + FRAC_BITS + 1;
  localparam int unsigned DV_W     = RB + 2;
  localparam int unsigned REM_W    = RB + 3;
  localparam int unsigned CNT_W    = $clog2(NUM_W + 1);

  step_e step_q, step_d;
  ctrl_t cw;
  logic  cond_true;

  logic [IN_W-1:0]     n_q;
  logic [ROOT_W-1:0]   r_q;
  logic [SQ_W-1:0]     sq_q;
  logic [NUM_W-1:0]    quo_q;
  logic [REM_W-1:0]    rem_q;
  logic [DV_W-1:0]     dv_q;
  logic [CNT_W-1:0]    cnt_q;
  logic [APPROX_W-1:0] newton_q;
  logic                out_valid_q;
  logic [APPROX_W-1:0] out_newton_q;
  logic [APPROX_W-1:0] out_interp_q;
  logic [ROOT_W-1:0]   out_root_q;

  logic [ROOT_W-1:0] a_w;
  logic [SQ_W-1:0]   asq_w;
  logic [NUM_W-1:0]  n_ext;
  logic [NUM_W-1:0]  sq_sh;
  logic [NUM_W-1:0]  asq_sh;
  logic              found;
  logic              use_upper;
  logic [ROOT_W-1:0] s_w;
  logic [SQ_W-1:0]   ssq_w;
  logic [NUM_W-1:0]  newton_num;
  logic [NUM_W-1:0]  interp_num;
  logic [REM_W-1:0]  trial;
  logic              ge;
  logic              div_last;
  logic              out_free;

  // Squares are tracked incrementally, so no multiplier is needed.
  assign a_w    = r_q - ROOT_W'(1);
  assign asq_w  = sq_q - SQ_W'({r_q, 1'b0}) + SQ_W'(1);
  assign n_ext  = NUM_W'(n_q);
  assign sq_sh  = NUM_W'(sq_q) << FRAC_BITS;
  assign asq_sh = NUM_W'(asq_w) << FRAC_BITS;
  assign found  = sq_sh >= n_ext;

  // The upper square is taken only when strictly nearer, or when the lower
  // root is zero and would divide by zero.
  assign use_upper = (({1'b0, sq_sh} + {1'b0, asq_sh}) < {n_ext, 1'b0})
                     || (a_w == '0);
  assign s_w        = use_upper ? r_q : a_w;
  assign ssq_w      = use_upper ? sq_q : asq_w;
  assign newton_num = (NUM_W'(ssq_w) << FRAC_BITS) + n_ext;
  assign interp_num = (NUM_W'(asq_w + SQ_W'(a_w)) << FRAC_BITS) + n_ext;

  assign trial    = {rem_q[REM_W-2:0], quo_q[NUM_W-1]};
  assign ge       = trial >= REM_W'(dv_q);
  assign div_last = cnt_q == CNT_W'(1);
  assign out_free = !out_valid_q || out_o.ready;

  always_comb begin
    cw = ucode_rom(step_q);
    unique case (cw.cond)
      COND_ALWAYS:   cond_true = 1'b1;
      COND_IN:       cond_true = in_i.valid;
      COND_FOUND:    cond_true = found;
      COND_DIV_LAST: cond_true = div_last;
      COND_OUT_FREE: cond_true = out_free;
      default:       cond_true = 1'b1;
    endcase
    step_d = cond_true ? cw.target : step_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cw.ld_in && cond_true) begin
      n_q  <= in_i.number_in;
      r_q  <= ROOT_W'(1);
      sq_q <= SQ_W'(1);
    end
    if (cw.search && !cond_true) begin
      r_q  <= r_q + ROOT_W'(1);
      sq_q <= sq_q + SQ_W'({r_q, 1'b1});
    end
    if (cw.setup_newton) begin
      quo_q <= newton_num;
      rem_q <= '0;
      dv_q  <= DV_W'({s_w, 1'b0});
      cnt_q <= CNT_W'(NUM_W);
    end
    if (cw.setup_interp) begin
      newton_q <= quo_q[APPROX_W-1:0];
      quo_q    <= interp_num;
      rem_q    <= '0;
      dv_q     <= DV_W'({a_w, 1'b1});
      cnt_q    <= CNT_W'(NUM_W);
    end
    if (cw.div) begin
      quo_q <= {quo_q[NUM_W-2:0], ge};
      rem_q <= ge ? (trial - REM_W'(dv_q)) : trial;
      cnt_q <= cnt_q - CNT_W'(1);
    end
    if (cw.out_load && cond_true) begin
      out_newton_q <= newton_q;
      out_interp_q <= quo_q[APPROX_W-1:0];
      out_root_q   <= r_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cw.out_load && cond_true) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign in_i.ready           = cw.ld_in;
  assign out_o.valid          = out_valid_q;
  assign out_o.approx_newton  = out_newton_q;
  assign out_o.approx_interp  = out_interp_q;
  assign out_o.int_root_upper = out_root_q;

  // A new transaction restarts the search at the first candidate root.
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> (step_q == STEP_SEARCH && r_q == ROOT_W'(1)))
    else $error("search did not restart at root one");

  // The partial remainder stays below the divisor during every divide step.
  a_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q == STEP_DIV_N || step_q == STEP_DIV_I) |-> (rem_q < REM_W'(dv_q)))
    else $error("divider remainder out of range");

  // A fresh result carries the smallest root whose square reaches the input.
  a_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> (found && (r_q == ROOT_W'(1) || asq_sh < n_ext)))
    else $error("upper root is not minimal");

endmodule

>>> dv/tb.sv
// ----------------------------------------------------------------------------
// tb: regression for sqrt_approx_nearest_square
// A driver feeds fixed-point numbers through the input channel and a monitor
// checks each result transaction against an in-bench model of the
// nearest-square Newton step, the linear interpolation and the upper root.
// Both channels idle at random, and the result side stalls for a long
// stretch once so that the block backs up onto its input.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sqa_pkg::*;

  localparam int unsigned FracBits = FracBitsDef;
  localparam int unsigned InW      = IntBitsDef + FracBitsDef;
  localparam int unsigned RootBits = (IntBitsDef + 1) / 2;
  localparam int unsigned RootW    = RootBits + 1;
  localparam int unsigned ApproxW  = RootBits + 1 + FracBitsDef;

  localparam int unsigned NumRandom  = 900;
  localparam int unsigned IdlePct    = 16;
  localparam int unsigned CalmFirst  = 400;
  localparam int unsigned CalmLast   = 550;
  localparam int unsigned HoldAt     = 150;
  localparam int unsigned HoldLen    = 2000;
  localparam int unsigned DrainWait  = 320;
  localparam int unsigned CycleLimit = 2_000_000;

  typedef struct packed {
    logic [ApproxW-1:0] newton;
    logic [ApproxW-1:0] interp;
    logic [RootW-1:0]   root;
  } sqrt_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  sqa_in_if  in_bus ();
  sqa_out_if out_bus ();

  sqrt_approx_nearest_square u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  always #2 clk_i = ~clk_i;

  logic [InW-1:0] pending_numbers[$];
  sqrt_result_t   expected_results[$];
  int unsigned    numbers_sent;
  int unsigned    results_seen;
  int unsigned    mismatches;
  int unsigned    hold_cycles;
  logic           hold_done;
  int unsigned    cycle_count;

  // Floors of the exact rational values; all arithmetic in 64 bits.
  function automatic sqrt_result_t nearest_square_approx(logic [InW-1:0] number);
    longint unsigned n, r, a, rsq, asq, s, newton, interp;
    sqrt_result_t res;
    n = number;
    r = 1;
    while (((r * r) << FracBits) < n) r++;
    a   = r - 1;
    rsq = (r * r) << FracBits;
    asq = (a * a) << FracBits;
    // The upper square wins only when strictly nearer, or when a is zero.
    if (rsq + asq < 2 * n || a == 0) s = r;
    else s = a;
    newton = (((s * s) << FracBits) + n) / (2 * s);
    interp = ((((a * a) + a) << FracBits) + n) / (2 * a + 1);
    res.newton = newton[ApproxW-1:0];
    res.interp = interp[ApproxW-1:0];
    res.root   = r[RootW-1:0];
    return res;
  endfunction

  function automatic logic [InW-1:0] clamp_number(longint signed v);
    if (v < 0) return '0;
    if (v > longint'((1 << InW) - 1)) return '1;
    return v[InW-1:0];
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    mismatches++;
    $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
  endtask

  // Driver: a new transaction is offered only once the previous one is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_bus.valid     <= 1'b0;
      in_bus.number_in <= '0;
    end else if (!in_bus.valid || in_bus.ready) begin
      if (pending_numbers.size() != 0 &&
          ((numbers_sent >= CalmFirst && numbers_sent < CalmLast) ||
           $urandom_range(0, 99) >= IdlePct)) begin
        in_bus.valid     <= 1'b1;
        in_bus.number_in <= pending_numbers.pop_front();
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  // Long result-side stall, started once after a number of results.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_cycles <= 0;
      hold_done   <= 1'b0;
    end else if (!hold_done && results_seen == HoldAt) begin
      hold_cycles <= HoldLen;
      hold_done   <= 1'b1;
    end else if (hold_cycles != 0) begin
      hold_cycles <= hold_cycles - 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= (hold_cycles == 0) &&
                       ((results_seen >= CalmFirst && results_seen < CalmLast) ||
                        $urandom_range(0, 99) >= IdlePct);
    end
  end

  // Monitor: predict on each accepted number, compare each accepted result.
  always @(posedge clk_i or negedge rst_ni) begin
    sqrt_result_t want;
    if (!rst_ni) begin
      numbers_sent <= 0;
      results_seen <= 0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        expected_results.push_back(nearest_square_approx(in_bus.number_in));
        numbers_sent <= numbers_sent + 1;
      end
      if (out_bus.valid && out_bus.ready) begin
        results_seen <= results_seen + 1;
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result transaction", out_bus.approx_newton, 0);
        end else begin
          want = expected_results.pop_front();
          if (out_bus.approx_newton !== want.newton)
            report_mismatch("approx_newton", out_bus.approx_newton, want.newton);
          if (out_bus.approx_interp !== want.interp)
            report_mismatch("approx_interp", out_bus.approx_interp, want.interp);
          if (out_bus.int_root_upper !== want.root)
            report_mismatch("int_root_upper", out_bus.int_root_upper, want.root);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("sqrt_approx_nearest_square regression: fail");
      $finish;
    end
  end

  initial begin
    longint signed k, v;
    int unsigned   pick;
    rst_ni = 1'b0;

    // Zero, the region where the lower root is zero, the first root step,
    // ties between squares, exact squares and the top of the range.
    pending_numbers = '{24'd0, 24'd1, 24'd127, 24'd128, 24'd129, 24'd255, 24'd256,
                        24'd257, 24'd639, 24'd640, 24'd641, 24'hFE0100, 24'hFE0101,
                        24'hFFFF00, 24'hFFFFFF, 24'd2534528, 24'd2534529,
                        24'h800000, 24'h7FFFFF, 24'hAAAAAA, 24'h555555};

    for (int i = 0; i < NumRandom; i++) begin
      pick = $urandom_range(0, 3);
      case (pick)
        0: v = $urandom_range(0, (1 << InW) - 1);
        1: begin
          k = $urandom_range(0, 1 << RootBits);
          v = ((k * k) << FracBits) + $urandom_range(0, 4) - 2;
        end
        2: begin
          // Midpoint between neighboring squares, where the tie rule decides.
          k = $urandom_range(1, (1 << RootBits) - 1);
          v = ((k * k + (k - 1) * (k - 1)) << (FracBits - 1)) + $urandom_range(0, 2) - 1;
        end
        default: v = $urandom_range(0, 1023);
      endcase
      pending_numbers.push_back(clamp_number(v));
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_numbers.size() != 0 || in_bus.valid) @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("sqrt_approx_nearest_square regression: pass");
    end else begin
      $display("sqrt_approx_nearest_square regression: fail");
    end
    $finish;
  end

endmodule
